// File: sv/pcx_rle_plane_decoder_defines.svh
// Assertion macros used by the PCX run-length decoder datapath.
`ifndef PCX_RLE_PLANE_DECODER_DEFINES_SVH
`define PCX_RLE_PLANE_DECODER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PCXRLE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define PCXRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pcxrle_pkg.sv
// Types and constants of the PCX run-length plane decoder.
`default_nettype none

package pcxrle_pkg;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_BIT_MODE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BYTES_PER_LINE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_COUNT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT   = 3'd4;

    localparam logic [7:0] RUN_MARK_MASK = 8'hC0;
    localparam logic [7:0] RUN_LEN_MASK  = 8'h3F;
    localparam logic [3:0] PIX_PER_BYTE  = 4'd8;

    typedef enum logic [0:0] {
        ST_BYTE,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic emit;
        logic use_held;
        logic last;
        logic arm_run;
        logic clear_pending;
        logic load_remain;
    } ctrl_cmd_t;

    typedef struct packed {
        logic finished;
        logic load_ok;
        logic run_pending;
        logic is_marker;
        logic run_len_zero;
        logic run_len_one;
        logic remain_one;
        logic emit_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/pcxrle_ctrl.sv
// Controller state machine of the PCX run-length decoder.
`default_nettype none

module pcxrle_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire pcxrle_pkg::dp_status_t status,
    output pcxrle_pkg::ctrl_cmd_t   cmd
);
    import pcxrle_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;
    logic        live;

    assign in_ready = (state_reg == ST_BYTE) && (status.load_ok || status.finished);
    assign accept   = in_valid && in_ready;
    assign live     = accept && !status.finished;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BYTE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: enter the run state only while repeats remain.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BYTE:
            begin
                if (live && status.run_pending && !status.run_len_zero
                    && !status.run_len_one && !status.emit_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.load_ok && (status.remain_one || status.emit_done))
                begin
                    state_next = ST_BYTE;
                end
            end
            default: state_next = ST_BYTE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_BYTE:
            begin
                if (live)
                begin
                    if (status.run_pending)
                    begin
                        cmd.clear_pending = 1'b1;
                        if (!status.run_len_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.load_remain = 1'b1;
                            cmd.last        = status.run_len_one || status.emit_done;
                        end
                    end
                    else if (status.is_marker)
                    begin
                        cmd.arm_run = 1'b1;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.use_held = 1'b1;
                if (status.load_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = status.remain_one || status.emit_done;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/pcxrle_dp.sv
// Datapath of the PCX run-length decoder: registers, counters, output stage.
`default_nettype none

`include "pcx_rle_plane_decoder_defines.svh"

module pcxrle_dp #(
    parameter int MAX_PLANES = 8,
    parameter int COORD_BITS = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [pcxrle_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire [15:0]                   cfg_data,
    input  wire [7:0]                    in_byte,
    input  wire pcxrle_pkg::ctrl_cmd_t   cmd,
    output pcxrle_pkg::dp_status_t       status,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [COORD_BITS-1:0]        out_row,
    output logic [COORD_BITS-1:0]        out_column,
    output logic [7:0]                   out_value,
    output logic [2:0]                   out_plane,
    output logic [3:0]                   pixels_valid,
    output logic                         last_in_run,
    output logic                         image_done
);
    import pcxrle_pkg::*;

    localparam logic [3:0] MAX_NP = 4'(MAX_PLANES);

    // Configuration registers.
    logic        one_bit_reg;
    logic [15:0] bpl_reg;
    logic [3:0]  planes_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    // Decode state.
    logic        pending_reg;
    logic [5:0]  run_len_reg;
    logic [5:0]  remain_reg;
    logic [7:0]  held_reg;
    logic [15:0] lbc_reg;
    logic [2:0]  plane_reg;
    logic [15:0] row_reg;
    logic        finished_reg;
    logic        out_valid_reg;

    // Output payload.
    logic [COORD_BITS-1:0] row_out_reg;
    logic [COORD_BITS-1:0] col_out_reg;
    logic [7:0]            value_out_reg;
    logic [2:0]            plane_out_reg;
    logic [3:0]            valid_out_reg;
    logic                  last_out_reg;
    logic                  done_out_reg;

    logic [15:0] bpl_eff;
    logic [3:0]  np_eff;
    logic [15:0] h_eff;
    logic [16:0] lbc_inc;
    logic [3:0]  plane_inc;
    logic [16:0] row_inc;
    logic        line_end;
    logic        planes_end;
    logic        rows_end;
    logic        emit_done;
    logic [18:0] col_wide;
    logic [18:0] width_wide;
    logic [18:0] width_left;
    logic [15:0] col_now;
    logic [3:0]  valid_now;
    logic        load_ok;

    assign bpl_eff = (bpl_reg == 16'd0) ? 16'd1 : bpl_reg;
    assign h_eff   = (height_reg == 16'd0) ? 16'd1 : height_reg;

    always_comb
    begin
        if (planes_reg == 4'd0)
        begin
            np_eff = 4'd1;
        end
        else if (planes_reg > MAX_NP)
        begin
            np_eff = MAX_NP;
        end
        else
        begin
            np_eff = planes_reg;
        end
    end

    assign lbc_inc    = {1'b0, lbc_reg} + 17'd1;
    assign plane_inc  = {1'b0, plane_reg} + 4'd1;
    assign row_inc    = {1'b0, row_reg} + 17'd1;
    assign line_end   = lbc_inc >= {1'b0, bpl_eff};
    assign planes_end = plane_inc >= np_eff;
    assign rows_end   = row_inc >= {1'b0, h_eff};
    assign emit_done  = line_end && planes_end && rows_end;

    // Pixel coverage against the unwrapped column.
    assign col_wide   = {lbc_reg, 3'b000};
    assign width_wide = {3'b000, width_reg};
    assign width_left = width_wide - col_wide;

    always_comb
    begin
        if (one_bit_reg)
        begin
            col_now = col_wide[15:0];
            if (col_wide >= width_wide)
            begin
                valid_now = 4'd0;
            end
            else if (width_left >= 19'(PIX_PER_BYTE))
            begin
                valid_now = PIX_PER_BYTE;
            end
            else
            begin
                valid_now = width_left[3:0];
            end
        end
        else
        begin
            col_now   = lbc_reg;
            valid_now = (lbc_reg < width_reg) ? 4'd1 : 4'd0;
        end
    end

    assign load_ok = !out_valid_reg || out_ready;

    assign status.finished     = finished_reg;
    assign status.load_ok      = load_ok;
    assign status.run_pending  = pending_reg;
    assign status.is_marker    = (in_byte & RUN_MARK_MASK) == RUN_MARK_MASK;
    assign status.run_len_zero = run_len_reg == 6'd0;
    assign status.run_len_one  = run_len_reg == 6'd1;
    assign status.remain_one   = remain_reg == 6'd1;
    assign status.emit_done    = emit_done;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_bit_reg <= 1'b0;
            bpl_reg     <= 16'd1;
            planes_reg  <= 4'd1;
            width_reg   <= 16'd1;
            height_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ONE_BIT_MODE:   one_bit_reg <= cfg_data[0];
                CFG_BYTES_PER_LINE: bpl_reg     <= cfg_data;
                CFG_PLANE_COUNT:    planes_reg  <= cfg_data[3:0];
                CFG_IMAGE_WIDTH:    width_reg   <= cfg_data;
                CFG_IMAGE_HEIGHT:   height_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Run and position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            run_len_reg   <= 6'd0;
            remain_reg    <= 6'd0;
            lbc_reg       <= 16'd0;
            plane_reg     <= 3'd0;
            row_reg       <= 16'd0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.arm_run)
            begin
                pending_reg <= 1'b1;
                run_len_reg <= 6'(in_byte & RUN_LEN_MASK);
            end
            else if (cmd.clear_pending)
            begin
                pending_reg <= 1'b0;
            end

            if (cmd.load_remain)
            begin
                remain_reg <= run_len_reg - 6'd1;
            end
            else if (cmd.emit && cmd.use_held)
            begin
                remain_reg <= remain_reg - 6'd1;
            end

            if (cmd.emit)
            begin
                if (line_end)
                begin
                    lbc_reg <= 16'd0;
                    if (planes_end)
                    begin
                        plane_reg <= 3'd0;
                        row_reg   <= row_inc[15:0];
                        if (rows_end)
                        begin
                            finished_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        plane_reg <= plane_inc[2:0];
                    end
                end
                else
                begin
                    lbc_reg <= lbc_inc[15:0];
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held run value and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_remain)
        begin
            held_reg <= in_byte;
        end
        if (cmd.emit)
        begin
            row_out_reg   <= row_reg[COORD_BITS-1:0];
            col_out_reg   <= col_now[COORD_BITS-1:0];
            value_out_reg <= cmd.use_held ? held_reg : in_byte;
            plane_out_reg <= plane_reg;
            valid_out_reg <= valid_now;
            last_out_reg  <= cmd.last;
            done_out_reg  <= emit_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = row_out_reg;
    assign out_column   = col_out_reg;
    assign out_value    = value_out_reg;
    assign out_plane    = plane_out_reg;
    assign pixels_valid = valid_out_reg;
    assign last_in_run  = last_out_reg;
    assign image_done   = done_out_reg;

    `PCXRLE_ASSERT(a_emit_has_room, !cmd.emit || load_ok, "emit while output stage full")
    `PCXRLE_ASSERT(a_no_emit_after_done, !(cmd.emit && finished_reg), "emit after last row")
    `PCXRLE_ASSERT(a_run_has_repeats, !(cmd.emit && cmd.use_held) || (remain_reg != 6'd0),
        "run repeat with empty count")
    `PCXRLE_ASSERT_NEXT(a_done_sets_finished, cmd.emit && emit_done,
        finished_reg && done_out_reg && last_out_reg, "image completion not recorded")

endmodule

`default_nettype wire

// File: sv/pcx_rle_plane_decoder.sv
// Top level of the PCX run-length plane decoder.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------------
//  config    in         cfg_we                 cfg_index, cfg_data
//  input     in         in_valid / in_ready    in_byte
//  result    out        out_valid / out_ready  out_row, out_column, out_value,
//                                              out_plane, pixels_valid, last_in_run,
//                                              image_done
//
// For a run, the value byte is accepted with the first result, then the controller
// stays in its run state for the remaining repeats, one result a cycle through the
// single output register unless out_ready stalls it, with in_ready low. Reset (rst_n,
// asynchronous) clears all control state and sets the registers to their defaults;
// no clearing pass follows. When out_ready is low the output register holds its
// transaction and input is held off until it drains. After the last row every input
// transaction is accepted and dropped until reset.
`default_nettype none

module pcx_rle_plane_decoder #(
    parameter int MAX_PLANES = 8,
    parameter int COORD_BITS = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // Configuration write port
    input  wire                                cfg_we,
    input  wire [pcxrle_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire [15:0]                         cfg_data,
    // Compressed byte stream
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire [7:0]                          in_byte,
    // Decoded bytes
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [COORD_BITS-1:0]              out_row,
    output logic [COORD_BITS-1:0]              out_column,
    output logic [7:0]                         out_value,
    output logic [2:0]                         out_plane,
    output logic [3:0]                         pixels_valid,
    output logic                               last_in_run,
    output logic                               image_done
);
    import pcxrle_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller: decides per transaction whether to arm a run, emit, or repeat.
    pcxrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: configuration, line/plane/row counters and the output register.
    pcxrle_dp #(
        .MAX_PLANES (MAX_PLANES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_byte      (in_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row      (out_row),
        .out_column   (out_column),
        .out_value    (out_value),
        .out_plane    (out_plane),
        .pixels_valid (pixels_valid),
        .last_in_run  (last_in_run),
        .image_done   (image_done)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the PCX run-length plane decoder: directed and random streams.
module testbench;
    import pcxrle_pkg::*;

    // Planes saturate here; matches the default parameter of the block.
    localparam int MAX_PLANES = 8;
    // Generous bound: every item as a 63-byte run, every result stalled, taken several times.
    localparam int CYCLE_LIMIT = 400000;
    // A marker or a dropped byte yields no result; give the block a margin to settle.
    localparam int SETTLE_CYCLES = 8;
    // Length of the one long receiver hold-off.
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PERCENT = 36;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 12;

    // One decoded byte as it leaves the block.
    typedef struct packed {
        logic [15:0] row;
        logic [15:0] column;
        logic [7:0]  value;
        logic [2:0]  plane;
        logic [3:0]  valid_pix;
        logic        last;
        logic        done;
    } decoded_t;

    // Drive every input to a known value from time zero.
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [15:0]             cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic [7:0]              in_byte = '0;
    logic                    out_ready = 1'b0;

    wire        in_ready;
    wire        out_valid;
    wire [15:0] out_row;
    wire [15:0] out_column;
    wire [7:0]  out_value;
    wire [2:0]  out_plane;
    wire [3:0]  pixels_valid;
    wire        last_in_run;
    wire        image_done;

    pcx_rle_plane_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row      (out_row),
        .out_column   (out_column),
        .out_value    (out_value),
        .out_plane    (out_plane),
        .pixels_valid (pixels_valid),
        .last_in_run  (last_in_run),
        .image_done   (image_done)
    );

    // Shadow copy of the registers, tracked from the write port.
    logic        mode_1bit  = 1'b0;
    logic [15:0] bpl_reg    = 16'd1;
    logic [3:0]  planes_reg = 4'd1;
    logic [15:0] width_reg  = 16'd1;
    logic [15:0] height_reg = 16'd1;

    // Shadow copy of the decoder state.
    logic        run_armed      = 1'b0;
    logic [5:0]  run_count      = '0;
    logic [15:0] line_pos       = '0;
    logic [2:0]  plane_idx      = '0;
    logic [15:0] row_idx        = '0;
    logic        image_finished = 1'b0;

    // Decoded bytes predicted but not yet seen on the result channel, oldest first.
    decoded_t pending_pixels[$];

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;

    // Idling controls, set by the test tasks.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int unsigned hold_asks = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: idle at random, or hold off for a long stretch when a test asks for it.
    always @(posedge clk) begin : receiver
        int unsigned hold_served;
        int unsigned hold_left;
        if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (rx_idle_on) begin
            out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Advance the shadow decoder by one accepted byte; queue the decoded bytes it yields.
    task automatic decode_pcx_byte(input logic [7:0] b);
        int unsigned repeats, lines, planes, rows;
        int unsigned col, valid, next_pos, next_plane, next_row, n;
        bit done;
        decoded_t d;
        // Drop everything once the last row is complete.
        if (image_finished)
            return;
        if (run_armed) begin
            run_armed = 1'b0;
            repeats = run_count;
        end else if ((b & RUN_MARK_MASK) == RUN_MARK_MASK) begin
            // Marker: arm the run, emit nothing.
            run_armed = 1'b1;
            run_count = 6'(b & RUN_LEN_MASK);
            return;
        end else begin
            repeats = 1;
        end
        // Zero bounds count as one; too many planes saturate.
        lines = (bpl_reg == 0) ? 1 : bpl_reg;
        planes = (planes_reg == 0) ? 1 : planes_reg;
        if (planes > MAX_PLANES)
            planes = MAX_PLANES;
        rows = (height_reg == 0) ? 1 : height_reg;
        done = 1'b0;
        n = 0;
        while (n < repeats && !done) begin
            // Validity uses the full column, before it is cut to 16 bits.
            if (mode_1bit) begin
                col = line_pos * 8;
                if (col >= width_reg)
                    valid = 0;
                else if (width_reg - col >= 8)
                    valid = 8;
                else
                    valid = width_reg - col;
            end else begin
                col = line_pos;
                valid = (col < width_reg) ? 1 : 0;
            end
            d.row = row_idx;
            d.column = col[15:0];
            d.value = b;
            d.plane = plane_idx;
            d.valid_pix = valid[3:0];
            d.last = (n + 1 == repeats);
            d.done = 1'b0;
            // Counters at or above a lowered bound close the line here.
            next_pos = line_pos + 1;
            if (next_pos >= lines) begin
                next_pos = 0;
                next_plane = plane_idx + 1;
                if (next_plane >= planes) begin
                    next_plane = 0;
                    next_row = row_idx + 1;
                    // Last row: cut the run short and flag both ends on this byte.
                    if (next_row >= rows) begin
                        image_finished = 1'b1;
                        done = 1'b1;
                        d.done = 1'b1;
                        d.last = 1'b1;
                    end
                    row_idx = next_row[15:0];
                end
                plane_idx = next_plane[2:0];
            end
            line_pos = next_pos[15:0];
            pending_pixels.push_back(d);
            n++;
        end
    endtask

    // Scoreboard: track register writes, predict on each input transaction,
    // check each result transaction against the oldest prediction.
    always @(posedge clk) begin : scoreboard
        decoded_t got;
        decoded_t want;
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ONE_BIT_MODE:   mode_1bit = cfg_data[0];
                    CFG_BYTES_PER_LINE: bpl_reg = cfg_data;
                    CFG_PLANE_COUNT:    planes_reg = cfg_data[3:0];
                    CFG_IMAGE_WIDTH:    width_reg = cfg_data;
                    CFG_IMAGE_HEIGHT:   height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                decode_pcx_byte(in_byte);
            if (out_valid && out_ready) begin
                got.row = out_row;
                got.column = out_column;
                got.value = out_value;
                got.plane = out_plane;
                got.valid_pix = pixels_valid;
                got.last = last_in_run;
                got.done = image_done;
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: %p", got));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.row !== want.row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                            got.row, want.row));
                    if (got.column !== want.column)
                        report_mismatch($sformatf("out_column %0d, want %0d",
                            got.column, want.column));
                    if (got.value !== want.value)
                        report_mismatch($sformatf("out_value %h, want %h",
                            got.value, want.value));
                    if (got.plane !== want.plane)
                        report_mismatch($sformatf("out_plane %0d, want %0d",
                            got.plane, want.plane));
                    if (got.valid_pix !== want.valid_pix)
                        report_mismatch($sformatf("pixels_valid %0d, want %0d",
                            got.valid_pix, want.valid_pix));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_in_run %b, want %b",
                            got.last, want.last));
                    if (got.done !== want.done)
                        report_mismatch($sformatf("image_done %b, want %b",
                            got.done, want.done));
                end
            end
        end
    end

    // Write one register; hold the enable for exactly one edge.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one byte after an optional random gap; return at the edge that accepts it.
    task automatic push_stream_byte(input logic [7:0] b);
        while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_run(input logic [5:0] len, input logic [7:0] value);
        push_stream_byte(RUN_MARK_MASK | {2'b00, len});
        push_stream_byte(value);
    endtask

    // Drop valid, wait for every predicted byte, then let the block settle.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Byte mode: literal extremes, a padding column, every kind of run.
    task automatic test_literal_and_runs();
        wait_for_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // Keep the image open for the whole run; the last test closes it.
        write_register(CFG_IMAGE_HEIGHT, 16'hFFFF);
        write_register(CFG_ONE_BIT_MODE, 0);
        write_register(CFG_BYTES_PER_LINE, 4);
        write_register(CFG_PLANE_COUNT, 3);
        write_register(CFG_IMAGE_WIDTH, 3);
        push_stream_byte(8'h00);
        push_stream_byte(8'h3F);
        push_stream_byte(8'h7F);
        push_stream_byte(8'h80);
        push_stream_byte(8'hBF);
        send_run(6'd1, 8'hFF);
        // Zero run: the value byte is swallowed.
        send_run(6'd0, 8'h55);
        // Longest run, with a value that looks like a marker.
        send_run(6'd63, 8'hC3);
        send_run(6'd5, 8'h00);
        push_stream_byte(8'h40);
    endtask

    // One-bit mode: eight pixels per byte, partial byte at the right edge.
    task automatic test_one_bit_planes();
        wait_for_drain();
        write_register(CFG_ONE_BIT_MODE, 1);
        write_register(CFG_BYTES_PER_LINE, 3);
        write_register(CFG_PLANE_COUNT, 4);
        write_register(CFG_IMAGE_WIDTH, 20);
        push_stream_byte(8'hAA);
        push_stream_byte(8'h55);
        push_stream_byte(8'h01);
        send_run(6'd7, 8'h0F);
        send_run(6'd2, 8'hF0);
        push_stream_byte(8'h80);
        push_stream_byte(8'h7E);
    endtask

    // Smallest and zero bounds, zero width, saturating plane count.
    task automatic test_degenerate_registers();
        wait_for_drain();
        write_register(CFG_ONE_BIT_MODE, 0);
        write_register(CFG_BYTES_PER_LINE, 1);
        write_register(CFG_PLANE_COUNT, 1);
        write_register(CFG_IMAGE_WIDTH, 1);
        push_stream_byte(8'h11);
        push_stream_byte(8'h22);
        wait_for_drain();
        write_register(CFG_BYTES_PER_LINE, 0);
        write_register(CFG_PLANE_COUNT, 0);
        write_register(CFG_IMAGE_WIDTH, 0);
        push_stream_byte(8'h33);
        send_run(6'd3, 8'h44);
        wait_for_drain();
        write_register(CFG_ONE_BIT_MODE, 1);
        write_register(CFG_PLANE_COUNT, 15);
        send_run(6'd10, 8'h99);
        push_stream_byte(8'h12);
    endtask

    // Random phases: mostly literals and runs with random content, some raw noise.
    task automatic test_random_stream();
        int unsigned phase, sent, pick, lines, eff_lines, mode, len;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_drain();
            mode = $urandom_range(1, 0);
            lines = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
            eff_lines = (lines == 0) ? 1 : lines;
            write_register(CFG_ONE_BIT_MODE, mode);
            write_register(CFG_BYTES_PER_LINE, lines);
            write_register(CFG_PLANE_COUNT, $urandom_range(15, 0));
            write_register(CFG_IMAGE_WIDTH,
                mode ? $urandom_range(eff_lines * 8 + 8, 0) : $urandom_range(eff_lines + 2, 0));
            if (phase == 3)
                write_register(CFG_IMAGE_HEIGHT, 40000);
            // Phase 2 runs with no idling at all; phase 5 fills the block behind a long hold.
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            if (phase == 5) begin
                tx_idle_on = 1'b0;
                hold_asks++;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    push_stream_byte(8'($urandom_range(191)));
                    sent += 1;
                end else if (pick < 85) begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(6, 1);
                    send_run(6'(len), 8'($urandom_range(255)));
                    sent += 2;
                end else begin
                    push_stream_byte(8'($urandom_range(255)));
                    sent += 1;
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // One very long scan line: columns pass 16 bits, then a lowered bound ends the line.
    task automatic test_wide_scan_line();
        wait_for_drain();
        // Run the long line with no idling on either side.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_register(CFG_ONE_BIT_MODE, 1);
        write_register(CFG_BYTES_PER_LINE, 16'hFFFF);
        write_register(CFG_PLANE_COUNT, 8);
        write_register(CFG_IMAGE_WIDTH, 16'hFFFF);
        repeat (131) send_run(6'd63, 8'($urandom_range(255)));
        push_stream_byte(8'h5A);
        push_stream_byte(8'hA5);
        wait_for_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_register(CFG_BYTES_PER_LINE, 5);
        push_stream_byte(8'h01);
        push_stream_byte(8'h02);
        push_stream_byte(8'h03);
    endtask

    // Close the image in the middle of a run, then check that input is dropped.
    task automatic test_last_row();
        wait_for_drain();
        write_register(CFG_ONE_BIT_MODE, 0);
        write_register(CFG_BYTES_PER_LINE, 2);
        write_register(CFG_PLANE_COUNT, 2);
        write_register(CFG_IMAGE_WIDTH, 2);
        write_register(CFG_IMAGE_HEIGHT, 0);
        send_run(6'd63, 8'h12);
        push_stream_byte(8'h01);
        send_run(6'd4, 8'h44);
        push_stream_byte(8'hC3);
        push_stream_byte(8'h00);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_literal_and_runs();
        test_one_bit_planes();
        test_degenerate_registers();
        test_random_stream();
        test_wide_scan_line();
        test_last_row();
        wait_for_drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
